// ----- hw/rtl/nct_pkg.sv -----
// ----------------------------------------------------------------------------
// nct_pkg
// Shared constants, request codes, controller states and the command/status
// structs that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package nct_pkg;

   localparam int ROW_BITS  = 32;
   localparam int MAX_ROWS  = 32;
   localparam int MAX_EDGES = 512;

   localparam int WORD_W     = 32;
   localparam int DATA_W     = (ROW_BITS < WORD_W) ? ROW_BITS : WORD_W;
   localparam int ROW_IDX_W  = $clog2(MAX_ROWS);
   localparam int ROW_CNT_W  = $clog2(MAX_ROWS + 1);
   localparam int EDGE_IDX_W = $clog2(MAX_EDGES);
   localparam int EDGE_CNT_W = $clog2(MAX_EDGES + 1);

   typedef enum logic [1:0] {
      REQ_CLEAR = 2'd0,
      REQ_ROW   = 2'd1,
      REQ_EDGE  = 2'd2,
      REQ_TEST  = 2'd3
   } req_code_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROWS,
      ST_EDGES,
      ST_DRAIN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic accept;      // request beat taken this cycle
      logic row_step;    // check one row against all others
      logic edge_issue;  // read next edge
      logic finish;      // load the test verdict into the response register
   } cmd_type;

   typedef struct packed {
      logic rows_empty;
      logic row_last;
      logic edge_done;
      logic rsp_busy;    // response register holds a beat not taken this cycle
   } status_type;

endpackage

// ----- hw/rtl/nct_intf.sv -----
// ----------------------------------------------------------------------------
// nct_req_if / nct_rsp_if
// Valid/ready channels for request and response beats.
// ----------------------------------------------------------------------------
interface nct_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [31:0] word;

   modport source (output valid, output req_type, output word, input ready);
   modport sink   (input valid, input req_type, input word, output ready);
endinterface

interface nct_rsp_if;
   logic valid;
   logic ready;
   logic passes;
   logic store_full;

   modport source (output valid, output passes, output store_full, input ready);
   modport sink   (input valid, input passes, input store_full, output ready);
endinterface

// ----- hw/rtl/nct_ram.sv -----
// ----------------------------------------------------------------------------
// nct_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module nct_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/nct_ctrl.sv -----
// ----------------------------------------------------------------------------
// nct_ctrl
// Sequencer: takes request beats, walks the row check and the edge scan of
// a candidate test, and hands the verdict to the response register.
// ----------------------------------------------------------------------------
module nct_ctrl import nct_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  req_code_type req_code,
   output logic         req_ready,
   input  status_type   status,
   output cmd_type      cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && !status.rsp_busy && req_code == REQ_TEST) begin
               state_in = status.rows_empty ? ST_EDGES : ST_ROWS;
            end
         end
         ST_ROWS: begin
            if (status.row_last) begin
               state_in = ST_EDGES;
            end
         end
         ST_EDGES: begin
            if (status.edge_done) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: state_in = ST_DONE;
         ST_DONE: begin
            if (!status.rsp_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready      = (state_ff == ST_IDLE) && !status.rsp_busy;
      cmd.accept     = req_valid && req_ready;
      cmd.row_step   = (state_ff == ST_ROWS);
      cmd.edge_issue = (state_ff == ST_EDGES) && !status.edge_done;
      cmd.finish     = (state_ff == ST_DONE) && !status.rsp_busy;
   end

endmodule

// ----- hw/rtl/nct_dp.sv -----
// ----------------------------------------------------------------------------
// nct_dp
// Datapath: row registers, edge RAM, counts, candidate register, the
// row-against-all-rows subset check, the edge subset check and the
// response register.
// ----------------------------------------------------------------------------
module nct_dp import nct_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   input  req_code_type      req_code,
   input  logic [WORD_W-1:0] req_word,
   output status_type        status,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_passes,
   output logic              rsp_store_full
);

   logic [DATA_W-1:0]     rows_ff [MAX_ROWS];
   logic [ROW_CNT_W-1:0]  row_cnt_ff, row_cnt_in;
   logic [EDGE_CNT_W-1:0] edge_cnt_ff, edge_cnt_in;
   logic [DATA_W-1:0]     x_ff;
   logic [ROW_IDX_W-1:0]  ri_ff;
   logic [EDGE_CNT_W-1:0] ea_ff;
   logic                  pend_ff;
   logic                  fail_ff, fail_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  passes_ff, passes_in;
   logic                  full_ff, full_in;

   logic [DATA_W-1:0] word_w;
   logic              row_room;
   logic              edge_room;
   logic              row_wr;
   logic              edge_wr;
   logic              rsp_load;
   logic [DATA_W-1:0] row_sel;
   logic [DATA_W-1:0] e_mask;
   logic              row_hit;
   logic [DATA_W-1:0] edge_rd;
   logic              edge_hit;

   assign word_w    = req_word[DATA_W-1:0];
   assign row_room  = row_cnt_ff < ROW_CNT_W'(MAX_ROWS);
   assign edge_room = edge_cnt_ff < EDGE_CNT_W'(MAX_EDGES);
   assign row_wr    = cmd.accept && req_code == REQ_ROW && row_room;
   assign edge_wr   = cmd.accept && req_code == REQ_EDGE && edge_room;
   assign rsp_load  = (cmd.accept && req_code != REQ_TEST) || cmd.finish;

   nct_ram #(
      .WIDTH (DATA_W),
      .DEPTH (MAX_EDGES)
   ) u_edge_ram (
      .clock   (clock),
      .wr_en   (edge_wr),
      .wr_addr (edge_cnt_ff[EDGE_IDX_W-1:0]),
      .wr_data (word_w),
      .rd_en   (cmd.edge_issue),
      .rd_addr (ea_ff[EDGE_IDX_W-1:0]),
      .rd_data (edge_rd)
   );

   // row i masked by the candidate must not fit inside any other stored row
   always_comb begin
      row_sel = rows_ff[ri_ff];
      e_mask  = x_ff & row_sel;
      row_hit = 1'b0;
      for (int j = 0; j < MAX_ROWS; j++) begin
         if (ROW_CNT_W'(j) < row_cnt_ff && ROW_IDX_W'(j) != ri_ff &&
             (e_mask & ~rows_ff[j]) == '0) begin
            row_hit = 1'b1;
         end
      end
   end

   assign edge_hit = pend_ff && ((edge_rd & ~x_ff) == '0);

   always_comb begin
      row_cnt_in  = row_cnt_ff;
      edge_cnt_in = edge_cnt_ff;
      if (cmd.accept && req_code == REQ_CLEAR) begin
         row_cnt_in  = '0;
         edge_cnt_in = '0;
      end
      if (row_wr) begin
         row_cnt_in = row_cnt_ff + 1'b1;
      end
      if (edge_wr) begin
         edge_cnt_in = edge_cnt_ff + 1'b1;
      end
   end

   always_comb begin
      fail_in = fail_ff;
      if (cmd.accept) begin
         fail_in = 1'b0;
      end else if ((cmd.row_step && row_hit) || edge_hit) begin
         fail_in = 1'b1;
      end
   end

   always_comb begin
      passes_in = passes_ff;
      full_in   = full_ff;
      if (cmd.finish) begin
         passes_in = !fail_ff;
         full_in   = 1'b0;
      end else if (cmd.accept) begin
         passes_in = 1'b0;
         full_in   = (req_code == REQ_ROW && !row_room) ||
                     (req_code == REQ_EDGE && !edge_room);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_cnt_ff   <= '0;
         edge_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         row_cnt_ff   <= row_cnt_in;
         edge_cnt_ff  <= edge_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= cmd.edge_issue;
      end
   end

   always_ff @(posedge clock) begin
      if (row_wr) begin
         rows_ff[row_cnt_ff[ROW_IDX_W-1:0]] <= word_w;
      end
      if (cmd.accept && req_code == REQ_TEST) begin
         x_ff  <= word_w;
         ri_ff <= '0;
         ea_ff <= '0;
      end else begin
         if (cmd.row_step) begin
            ri_ff <= ri_ff + 1'b1;
         end
         if (cmd.edge_issue) begin
            ea_ff <= ea_ff + 1'b1;
         end
      end
      fail_ff   <= fail_in;
      passes_ff <= passes_in;
      full_ff   <= full_in;
   end

   assign status.rows_empty = (row_cnt_ff == '0);
   assign status.row_last   = (ROW_CNT_W'(ri_ff) + 1'b1 == row_cnt_ff);
   assign status.edge_done  = (ea_ff == edge_cnt_ff);
   assign status.rsp_busy   = rsp_valid_ff && !rsp_ready;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_passes     = passes_ff;
   assign rsp_store_full = full_ff;

   a_row_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      row_cnt_ff <= ROW_CNT_W'(MAX_ROWS))
      else $error("row count beyond capacity");

   a_edge_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      edge_cnt_ff <= EDGE_CNT_W'(MAX_EDGES))
      else $error("edge count beyond capacity");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> !(rsp_valid_ff && !rsp_ready))
      else $error("response register overwritten before it was taken");

   a_pend_follows_read: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> $past(cmd.edge_issue))
      else $error("edge compare without a preceding read");

endmodule

// ----- hw/rtl/neighborly_candidate_test.sv -----
// ----------------------------------------------------------------------------
// neighborly_candidate_test
// Keeps a store of row masks and a store of edge masks; appends, clears and
// tests candidate masks against both stores, one response beat per request.
//
//   channel   dir  beat contents
//   req_bus   in   req_type[1:0], word[31:0]
//   rsp_bus   out  passes, store_full
//
// A test checks each stored row in turn (that row masked by the candidate
// against all rows at once), then issues one edge RAM read per stored
// edge, compares the last read, passes through a drain state and loads the
// verdict. Synchronous reset empties both stores; no clearing pass is needed.
// A stalled response beat holds the sequencer; a new request is taken only
// while the response register is empty or being drained.
// ----------------------------------------------------------------------------
module neighborly_candidate_test import nct_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   nct_req_if.sink   req_bus,
   nct_rsp_if.source rsp_bus
);

   cmd_type      cmd;
   status_type   status;
   req_code_type req_code;

   assign req_code = req_code_type'(req_bus.req_type);

   nct_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_code  (req_code),
      .req_ready (req_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   nct_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_code       (req_code),
      .req_word       (req_bus.word),
      .status         (status),
      .rsp_valid      (rsp_bus.valid),
      .rsp_ready      (rsp_bus.ready),
      .rsp_passes     (rsp_bus.passes),
      .rsp_store_full (rsp_bus.store_full)
   );

endmodule

// ----- tb/tb_neighborly_candidate_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_neighborly_candidate_test
// Self-checking bench for the candidate tester. Requests (clear, row append,
// edge append, candidate test) go in through a valid/ready driver fed from a
// queue. A shadow copy of both stores predicts each response beat. A monitor
// checks every beat against the oldest prediction. Both sides idle in random
// bursts. The receiver holds off once for a long stretch, and the sender
// drains fully at phase boundaries. Both stores are filled past capacity.
// ----------------------------------------------------------------------------
module tb_neighborly_candidate_test;
   import nct_pkg::*;

   localparam int CYCLE_LIMIT  = 4_000_000;
   localparam int HOLD_CYCLES  = 300;
   localparam int TAIL_CYCLES  = MAX_ROWS + MAX_EDGES + 40;
   localparam int RANDOM_ITEMS = 640;

   typedef struct packed {
      req_code_type kind;
      logic [31:0]  word;
   } request_type;

   typedef struct packed {
      logic passes;
      logic store_full;
   } verdict_type;

   logic clock;
   logic reset;

   nct_req_if req_bus ();
   nct_rsp_if rsp_bus ();

   neighborly_candidate_test u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // shadow copy of the stores
   logic [DATA_W-1:0] row_mem  [MAX_ROWS];
   logic [DATA_W-1:0] pair_mem [MAX_EDGES];
   int n_rows  = 0;
   int n_pairs = 0;

   request_type pend_q[$];
   verdict_type verdict_q[$];

   int          n_err       = 0;
   int          n_sent      = 0;
   int unsigned n_cycles    = 0;
   int          src_gap_pct = 0;
   int          snk_gap_pct = 0;
   int          src_idle    = 0;
   int          snk_idle    = 0;
   bit          hold_go     = 1'b0;
   logic        hold_off;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   initial begin
      reset           = 1'b1;
      req_bus.valid    = 1'b0;
      req_bus.req_type = REQ_CLEAR;
      req_bus.word     = '0;
      rsp_bus.ready    = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
   end

   // Updates the shadow stores for one accepted request and returns its verdict.
   function automatic verdict_type apply_request(request_type rq);
      verdict_type       v;
      logic [DATA_W-1:0] x;
      logic [DATA_W-1:0] hit;
      bit                reject;
      v      = '0;
      reject = 1'b0;
      x      = rq.word[DATA_W-1:0];
      case (rq.kind)
         REQ_CLEAR: begin
            n_rows  = 0;
            n_pairs = 0;
         end
         REQ_ROW: begin
            if (n_rows < MAX_ROWS) begin
               row_mem[n_rows] = x;
               n_rows++;
            end else begin
               v.store_full = 1'b1;
            end
         end
         REQ_EDGE: begin
            if (n_pairs < MAX_EDGES) begin
               pair_mem[n_pairs] = x;
               n_pairs++;
            end else begin
               v.store_full = 1'b1;
            end
         end
         default: begin
            // candidate fails if a masked row fits inside another row
            for (int i = 0; i < n_rows; i++) begin
               hit = x & row_mem[i];
               for (int j = 0; j < n_rows; j++)
                  if (i != j && (hit & ~row_mem[j]) == '0) reject = 1'b1;
            end
            // or if any stored edge fits inside the candidate
            for (int i = 0; i < n_pairs; i++)
               if ((pair_mem[i] & ~x) == '0) reject = 1'b1;
            v.passes = !reject;
         end
      endcase
      return v;
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         src_idle = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            verdict_q = {verdict_q, apply_request(pend_q[0])};
            pend_q.pop_front();
         end
         if (req_bus.valid && !req_bus.ready) begin
            // beat still pending, keep it on the bus
         end else if (src_idle > 0) begin
            req_bus.valid <= 1'b0;
            src_idle--;
         end else if (pend_q.size() != 0 && src_gap_pct != 0
                      && $urandom_range(99) < src_gap_pct) begin
            req_bus.valid <= 1'b0;
            src_idle = $urandom_range(12);
         end else if (pend_q.size() != 0) begin
            req_bus.valid    <= 1'b1;
            req_bus.req_type <= pend_q[0].kind;
            req_bus.word     <= pend_q[0].word;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // response monitor
   always @(posedge clock) begin : monitor
      verdict_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         snk_idle = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (verdict_q.size() == 0) begin
               $error("response beat with no request outstanding");
               n_err++;
            end else begin
               want = verdict_q.pop_front();
               if (rsp_bus.passes !== want.passes) begin
                  $error("passes: expected %0b, got %0b", want.passes, rsp_bus.passes);
                  n_err++;
               end
               if (rsp_bus.store_full !== want.store_full) begin
                  $error("store_full: expected %0b, got %0b",
                         want.store_full, rsp_bus.store_full);
                  n_err++;
               end
            end
         end
         if (hold_off) begin
            rsp_bus.ready <= 1'b0;
         end else if (snk_idle > 0) begin
            rsp_bus.ready <= 1'b0;
            snk_idle--;
         end else if (snk_gap_pct != 0 && $urandom_range(99) < snk_gap_pct) begin
            rsp_bus.ready <= 1'b0;
            snk_idle = $urandom_range(12);
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // long receiver hold-off so the block backs up into the request side
   initial begin
      hold_off = 1'b0;
      wait (hold_go);
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off <= 1'b0;
   end

   always @(posedge clock) begin
      n_cycles++;
      if (n_cycles > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic send(req_code_type k, logic [31:0] w);
      request_type rq;
      rq.kind = k;
      rq.word = w;
      pend_q  = {pend_q, rq};
      n_sent++;
   endtask

   task automatic wait_room();
      while (pend_q.size() > 8) @(posedge clock);
   endtask

   task automatic wait_drained();
      while (pend_q.size() != 0 || verdict_q.size() != 0) @(posedge clock);
   endtask

   function automatic int gap_pct();
      case ($urandom_range(3))
         0:       return 0;
         1:       return 5;
         2:       return 20;
         default: return 40;
      endcase
   endfunction

   function automatic logic [31:0] rand_mask();
      case ($urandom_range(6))
         0:       return $urandom & $urandom;
         1:       return $urandom & $urandom & $urandom;
         2:       return $urandom | $urandom;
         3:       return 32'd1 << $urandom_range(31);
         4:       return ($urandom_range(1) != 0) ? 32'hFFFF_FFFF : 32'h0;
         default: return $urandom;
      endcase
   endfunction

   // edges are mostly vertex pairs
   function automatic logic [31:0] pair_word();
      return (32'd1 << $urandom_range(31)) | (32'd1 << $urandom_range(31));
   endfunction

   function automatic logic [31:0] candidate_word(logic [31:0] rows[$]);
      int k;
      k = (rows.size() != 0) ? $urandom_range(rows.size() - 1) : 0;
      case ($urandom_range(3))
         0: return rand_mask();
         1: return (rows.size() != 0) ? ~rows[k] | ($urandom & $urandom & $urandom)
                                      : $urandom;
         2: return $urandom | $urandom;
         default: return (rows.size() != 0) ? rows[k] | ($urandom & $urandom) : 32'hFFFF_FFFF;
      endcase
   endfunction

   // clear, then interleaved appends with tests mixed in and at the end
   task automatic grow_and_test(int max_rows, int max_pairs, int max_tests);
      logic [31:0] rows[$];
      logic [31:0] x;
      int          nr;
      int          ne;
      int          nt;
      nr = $urandom_range(max_rows);
      ne = $urandom_range(max_pairs);
      nt = $urandom_range(max_tests, 1);
      send(REQ_CLEAR, $urandom);
      while (nr + ne + nt > 0) begin
         if (nt > 0 && (nr + ne == 0 || $urandom_range(5) == 0)) begin
            send(REQ_TEST, candidate_word(rows));
            nt--;
         end else if (nr > 0 && (ne == 0 || $urandom_range(1) == 0)) begin
            x = rand_mask();
            rows = {rows, x};
            send(REQ_ROW, x);
            nr--;
         end else begin
            send(REQ_EDGE, ($urandom_range(3) == 0) ? rand_mask() : pair_word());
            ne--;
         end
      end
   endtask

   task automatic fill_rows();
      logic [31:0] rows[$];
      logic [31:0] x;
      send(REQ_CLEAR, $urandom);
      repeat (MAX_ROWS + 3) begin
         x = $urandom;
         rows = {rows, x};
         send(REQ_ROW, x);
      end
      repeat (5) send(REQ_TEST, candidate_word(rows));
      send(REQ_EDGE, pair_word());
      send(REQ_TEST, $urandom | $urandom);
   endtask

   task automatic fill_pairs();
      logic [31:0] rows[$];
      logic [31:0] x;
      send(REQ_CLEAR, $urandom);
      repeat (3) begin
         x = $urandom;
         rows = {rows, x};
         send(REQ_ROW, x);
      end
      repeat (MAX_EDGES + 2) send(REQ_EDGE, $urandom | $urandom);
      repeat (3) send(REQ_TEST, candidate_word(rows));
      send(REQ_TEST, 32'hFFFF_FFFF);
      send(REQ_ROW, $urandom);
      send(REQ_EDGE, pair_word());
      send(REQ_TEST, $urandom);
   endtask

   task automatic noise_burst();
      repeat ($urandom_range(15, 4)) send(req_code_type'($urandom_range(3)), $urandom);
   endtask

   initial begin : stimulus
      int base;
      int scen;
      scen = 0;
      // empty stores pass anything
      send(REQ_TEST, 32'h0);
      send(REQ_TEST, 32'hFFFF_FFFF);
      // single row has nothing to compare with
      send(REQ_ROW, 32'hFFFF_FFFF);
      send(REQ_TEST, 32'h0);
      send(REQ_ROW, 32'h0);
      send(REQ_TEST, 32'hFFFF_FFFF);
      send(REQ_CLEAR, 32'hFFFF_FFFF);
      send(REQ_ROW, 32'h0000_FFFF);
      send(REQ_ROW, 32'hFFFF_0000);
      send(REQ_TEST, 32'h00FF_00FF);
      send(REQ_TEST, 32'hFFFF_FFFF);
      send(REQ_TEST, 32'h0);
      send(REQ_CLEAR, 32'h0);
      send(REQ_EDGE, 32'h8000_0001);
      send(REQ_TEST, 32'h8000_0001);
      send(REQ_TEST, 32'h7FFF_FFFE);
      // zero edge rejects every candidate
      send(REQ_EDGE, 32'h0);
      send(REQ_TEST, 32'h7FFF_FFFE);
      send(REQ_CLEAR, 32'h5A5A_A5A5);
      send(REQ_TEST, 32'h1234_5678);
      wait_drained();

      base = n_sent;
      while (n_sent - base < RANDOM_ITEMS) begin
         wait_room();
         src_gap_pct = gap_pct();
         snk_gap_pct = gap_pct();
         scen++;
         if (scen == 4) begin
            hold_go = 1'b1;
            grow_and_test(8, 6, 6);
            grow_and_test(8, 6, 6);
            grow_and_test(8, 6, 6);
         end else if (scen == 6) begin
            wait_drained();
            fill_rows();
         end else if (scen == 8) begin
            wait_drained();
            fill_pairs();
         end else if ($urandom_range(7) == 0) begin
            wait_drained();
            grow_and_test(8, 10, 6);
         end else if ($urandom_range(5) == 0) begin
            noise_burst();
         end else if ($urandom_range(9) == 0) begin
            grow_and_test(MAX_ROWS, 24, 8);
         end else begin
            grow_and_test(8, 10, 6);
         end
      end

      // closing stretch at full rate
      src_gap_pct = 0;
      snk_gap_pct = 0;
      repeat (2) grow_and_test(8, 10, 6);
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (n_err == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

// ----- neighborly_candidate_test.f -----
hw/rtl/nct_pkg.sv
hw/rtl/nct_intf.sv
hw/rtl/nct_ram.sv
hw/rtl/nct_ctrl.sv
hw/rtl/nct_dp.sv
hw/rtl/neighborly_candidate_test.sv
tb/tb_neighborly_candidate_test.sv
